@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; all use the local clock and reset signals.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// b holds in the same cycle as a
`define ASSERT_IMP(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) else $error(msg);

// b holds in the cycle after a
`define ASSERT_NEXT(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/csws_pkg.sv @@
// ----------------------------------------------------------------------------
// csws_pkg
// Shared types and constants for the card stack with shuffle.
// ----------------------------------------------------------------------------
package csws_pkg;

   localparam int unsigned RANKS     = 13;
   localparam int unsigned SUITS     = 4;
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
   localparam int unsigned SEED_W    = 32;

   typedef enum logic [2:0] {
      ACT_NEW_DECK = 3'd0,
      ACT_ADD_DECK = 3'd1,
      ACT_PUSH     = 3'd2,
      ACT_APPEND   = 3'd3,
      ACT_POP      = 3'd4,
      ACT_SHUFFLE  = 3'd5,
      ACT_SPARE_A  = 3'd6,
      ACT_SPARE_B  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECK,
      ST_SHUF,
      ST_STEP,
      ST_MODW,
      ST_RDB,
      ST_WRA,
      ST_WRB,
      ST_POPR,
      ST_POPD,
      ST_FIN
   } state_type;

endpackage

@@ hw/rtl/csws_store.sv @@
// ----------------------------------------------------------------------------
// csws_store
// Card memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csws_store #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [5:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [5:0]    rd_data
);

   logic [5:0] mem [DEPTH];
   logic [5:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/csws_mod.sv @@
// ----------------------------------------------------------------------------
// csws_mod
// Bit-serial remainder of a 32-bit value by a small divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module csws_mod #(
   parameter int unsigned DW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [csws_pkg::SEED_W-1:0]   dividend,
   input  logic [DW-1:0]                 divisor,
   output logic                          done,
   output logic [DW-1:0]                 remainder
);

   localparam int unsigned CNTW = $clog2(csws_pkg::SEED_W + 1);

   logic                        busy_ff, busy_in;
   logic [CNTW-1:0]             cnt_ff, cnt_in;
   logic [csws_pkg::SEED_W-1:0] num_ff, num_in;
   logic [DW-1:0]               den_ff, den_in;
   logic [DW-1:0]               rem_ff, rem_in;
   logic [DW:0]                 trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[csws_pkg::SEED_W-1]};
      done    = busy_ff && (cnt_ff == '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(csws_pkg::SEED_W);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNTW'(1);
            num_in = {num_ff[csws_pkg::SEED_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DW'(trial - {1'b0, den_ff});
            end else begin
               rem_in = DW'(trial);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;

endmodule

@@ hw/rtl/card_stack_with_shuffle_core.sv @@
// ----------------------------------------------------------------------------
// card_stack_with_shuffle_core
// Bounded card stack in a circular memory with deck loading and shuffle.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    action, card_rank, card_suit, seed
//   rsp       out        rsp_valid/stall    out_rank/suit, present, status, count
//
// Push, append, pop on an empty stack and unused actions go straight to the
// finish state; a pop with a card first reads the top card in ST_POPR and ST_POPD.
// A new_deck writes one card a cycle, 52 cards in all.
// A shuffle of n cards makes n-1 swaps; each swap runs the bit-serial
// remainder unit and then reads and writes both cards through the single
// memory port pair; an add_deck loads the deck and then shuffles all n cards.
// Reset is synchronous; the card memory is not cleared.
// req_stall is high while an item is in progress; a stalled result holds
// the finish state for as long as rsp_stall stays high.
// ----------------------------------------------------------------------------
module card_stack_with_shuffle_core #(
   parameter int unsigned STORE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_card_rank,
   input  logic [1:0]  req_card_suit,
   input  logic [31:0] req_shuffle_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_out_rank,
   output logic [1:0]  rsp_out_suit,
   output logic        rsp_card_present,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_card_count
);

   `include "assert_macros.svh"

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

   csws_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  top_ff, top_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [31:0]    lfsr_ff, lfsr_in;
   logic [31:0]    seed_ff, seed_in;
   logic [AW-1:0]  cur_ff, cur_in;
   logic [AW-1:0]  j_ff, j_in;
   logic [5:0]     tmp_ff, tmp_in;
   logic [3:0]     rank_ff, rank_in;
   logic [1:0]     suit_ff, suit_in;
   logic [2:0]     act_ff, act_in;
   logic [1:0]     status_ff, status_in;
   logic [5:0]     card_ff, card_in;
   logic           present_ff, present_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [3:0]     rsp_rank_ff, rsp_rank_in;
   logic [1:0]     rsp_suit_ff, rsp_suit_in;
   logic           rsp_present_ff, rsp_present_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [8:0]     rsp_count_ff, rsp_count_in;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [5:0]     mem_wdata, mem_rdata;
   logic           mod_start, mod_done;
   logic [31:0]    mod_dividend;
   logic [AW:0]    mod_divisor, mod_rem;
   logic [31:0]    lfsr_step;
   logic [AW-1:0]  top_dec;
   logic           has_room;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] top,
                                             input logic [AW-1:0] k);
      logic [AW:0] sum;
      sum = {1'b0, top} + {1'b0, k};
      if (sum >= (AW+1)'(STORE_DEPTH)) begin
         sum = sum - (AW+1)'(STORE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? csws_pkg::LFSR_TAPS : 32'h0);
   assign top_dec   = (top_ff == '0) ? AW'(STORE_DEPTH - 1) : top_ff - AW'(1);
   assign has_room  = cnt_ff < CW'(STORE_DEPTH);

   always_comb begin
      state_in     = state_ff;
      top_in       = top_ff;
      cnt_in       = cnt_ff;
      lfsr_in      = lfsr_ff;
      seed_in      = seed_ff;
      cur_in       = cur_ff;
      j_in         = j_ff;
      tmp_in       = tmp_ff;
      rank_in      = rank_ff;
      suit_in      = suit_ff;
      act_in       = act_ff;
      status_in    = status_ff;
      card_in      = card_ff;
      present_in   = present_ff;
      mem_we       = 1'b0;
      mem_waddr    = top_dec;
      mem_wdata    = {rank_ff, suit_ff};
      mem_raddr    = top_ff;
      mod_start    = 1'b0;
      mod_dividend = lfsr_step;
      mod_divisor  = {1'b0, cur_ff} + (AW+1)'(1);
      req_stall    = 1'b1;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_rank_in    = rsp_rank_ff;
      rsp_suit_in    = rsp_suit_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;

      case (state_ff)
         csws_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               act_in     = req_action;
               seed_in    = req_shuffle_seed;
               status_in  = csws_pkg::STS_OK;
               card_in    = '0;
               present_in = 1'b0;
               rank_in    = 4'd1;
               suit_in    = 2'd0;
               state_in   = csws_pkg::ST_FIN;
               case (req_action)
                  csws_pkg::ACT_NEW_DECK: begin
                     top_in   = '0;
                     cnt_in   = '0;
                     state_in = csws_pkg::ST_DECK;
                  end
                  csws_pkg::ACT_ADD_DECK: state_in = csws_pkg::ST_DECK;
                  csws_pkg::ACT_PUSH: begin
                     mem_wdata = {req_card_rank, req_card_suit};
                     if (has_room) begin
                        mem_we = 1'b1;
                        top_in = top_dec;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        status_in = csws_pkg::STS_FULL;
                     end
                  end
                  csws_pkg::ACT_APPEND: begin
                     mem_wdata = {req_card_rank, req_card_suit};
                     mem_waddr = slot_of(top_ff, AW'(cnt_ff));
                     if (has_room) begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        status_in = csws_pkg::STS_FULL;
                     end
                  end
                  csws_pkg::ACT_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = csws_pkg::STS_EMPTY;
                     end else begin
                        state_in = csws_pkg::ST_POPR;
                     end
                  end
                  csws_pkg::ACT_SHUFFLE: state_in = csws_pkg::ST_SHUF;
                  default: state_in = csws_pkg::ST_FIN;
               endcase
            end
         end
         csws_pkg::ST_DECK: begin
            if (has_room) begin
               mem_we = 1'b1;
               top_in = top_dec;
               cnt_in = cnt_ff + CW'(1);
            end else begin
               status_in = csws_pkg::STS_FULL;
            end
            if (rank_ff == 4'(csws_pkg::RANKS)) begin
               rank_in = 4'd1;
               suit_in = suit_ff + 2'd1;
               if (suit_ff == 2'(csws_pkg::SUITS - 1)) begin
                  state_in = (act_ff == csws_pkg::ACT_ADD_DECK) ?
                             csws_pkg::ST_SHUF : csws_pkg::ST_FIN;
               end
            end else begin
               rank_in = rank_ff + 4'd1;
            end
         end
         csws_pkg::ST_SHUF: begin
            lfsr_in = (seed_ff == '0) ? 32'd1 : seed_ff;
            if (cnt_ff <= CW'(1)) begin
               state_in = csws_pkg::ST_FIN;
            end else begin
               cur_in   = AW'(cnt_ff - CW'(1));
               state_in = csws_pkg::ST_STEP;
            end
         end
         csws_pkg::ST_STEP: begin
            lfsr_in   = lfsr_step;
            mod_start = 1'b1;
            state_in  = csws_pkg::ST_MODW;
         end
         csws_pkg::ST_MODW: begin
            mem_raddr = slot_of(top_ff, cur_ff);
            if (mod_done) begin
               j_in     = AW'(mod_rem);
               state_in = csws_pkg::ST_RDB;
            end
         end
         csws_pkg::ST_RDB: begin
            tmp_in    = mem_rdata;
            mem_raddr = slot_of(top_ff, j_ff);
            state_in  = csws_pkg::ST_WRA;
         end
         csws_pkg::ST_WRA: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(top_ff, cur_ff);
            mem_wdata = mem_rdata;
            state_in  = csws_pkg::ST_WRB;
         end
         csws_pkg::ST_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(top_ff, j_ff);
            mem_wdata = tmp_ff;
            if (cur_ff == AW'(1)) begin
               state_in = csws_pkg::ST_FIN;
            end else begin
               cur_in   = cur_ff - AW'(1);
               state_in = csws_pkg::ST_STEP;
            end
         end
         csws_pkg::ST_POPR: state_in = csws_pkg::ST_POPD;
         csws_pkg::ST_POPD: begin
            card_in    = mem_rdata;
            present_in = 1'b1;
            top_in     = (top_ff == AW'(STORE_DEPTH - 1)) ? '0 : top_ff + AW'(1);
            cnt_in     = cnt_ff - CW'(1);
            state_in   = csws_pkg::ST_FIN;
         end
         csws_pkg::ST_FIN: begin
            // hold until the output beat is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_rank_in    = card_ff[5:2];
               rsp_suit_in    = card_ff[1:0];
               rsp_present_in = present_ff;
               rsp_status_in  = status_ff;
               rsp_count_in   = 9'(cnt_ff);
               state_in       = csws_pkg::ST_IDLE;
            end
         end
         default: state_in = csws_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csws_pkg::ST_IDLE;
         top_ff       <= '0;
         cnt_ff       <= '0;
         lfsr_ff      <= 32'd1;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         lfsr_ff      <= lfsr_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seed_ff        <= seed_in;
      j_ff           <= j_in;
      tmp_ff         <= tmp_in;
      rank_ff        <= rank_in;
      suit_ff        <= suit_in;
      act_ff         <= act_in;
      status_ff      <= status_in;
      card_ff        <= card_in;
      present_ff     <= present_in;
      rsp_rank_ff    <= rsp_rank_in;
      rsp_suit_ff    <= rsp_suit_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   csws_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   csws_mod #(
      .DW (AW + 1)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_rank     = rsp_rank_ff;
   assign rsp_out_suit     = rsp_suit_ff;
   assign rsp_card_present = rsp_present_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_card_count   = rsp_count_ff;

   `ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CW'(STORE_DEPTH), "card count above depth")
   `ASSERT_IMP(a_rsp_from_fin, rsp_valid_in && !rsp_valid_ff, state_ff == csws_pkg::ST_FIN, "result raised outside finish")
   `ASSERT_IMP(a_wrb_after_wra, state_ff == csws_pkg::ST_WRB, $past(state_ff) == csws_pkg::ST_WRA, "swap write out of order")
   `ASSERT_NEXT(a_mod_to_rdb, state_ff == csws_pkg::ST_MODW && mod_done, state_ff == csws_pkg::ST_RDB, "swap read did not follow remainder")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives action beats into the card stack core and checks every response
// beat against an in-bench model of the stack, deck loading and shuffle.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned DEPTH       = 256;
   localparam int unsigned RANDOM_ITEMS = 527;
   localparam int unsigned IDLE_LIMIT  = 40000;

   typedef struct packed {
      logic [3:0] rank;
      logic [1:0] suit;
      logic       present;
      logic [1:0] status;
      logic [8:0] count;
   } card_reply_type;

   class stack_scoreboard_type;
      logic [5:0]     cards [DEPTH];
      logic [7:0]     top;
      int unsigned    held;
      logic [31:0]    lfsr;
      card_reply_type pending[$];
      int unsigned    errors;

      function new();
         top = 0;
         held = 0;
         lfsr = 1;
         errors = 0;
      endfunction

      function bit put_top(logic [5:0] c);
         if (held >= DEPTH) return 0;
         top = top - 8'd1;
         cards[top] = c;
         held++;
         return 1;
      endfunction

      function bit load_deck();
         bit ok;
         ok = 1;
         for (int s = 0; s < csws_pkg::SUITS; s++)
            for (int v = 1; v <= csws_pkg::RANKS; v++)
               if (!put_top({v[3:0], s[1:0]})) ok = 0;
         return ok;
      endfunction

      function void shuffle(logic [31:0] seed);
         logic [7:0] a, b;
         logic [5:0] t;
         logic [31:0] j;
         lfsr = (seed == 0) ? 32'd1 : seed;
         if (held <= 1) return;
         for (int unsigned i = held - 1; i > 0; i--) begin
            lfsr = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? csws_pkg::LFSR_TAPS : 32'd0);
            j = lfsr % (i + 1);
            a = top + i[7:0];
            b = top + j[7:0];
            t = cards[a];
            cards[a] = cards[b];
            cards[b] = t;
         end
      endfunction

      function void note_request(logic [2:0] act, logic [3:0] rank, logic [1:0] suit,
                                 logic [31:0] seed);
         card_reply_type r;
         r = '0;
         case (act)
            csws_pkg::ACT_NEW_DECK: begin
               top = 0;
               held = 0;
               if (!load_deck()) r.status = csws_pkg::STS_FULL;
            end
            csws_pkg::ACT_ADD_DECK: begin
               if (!load_deck()) r.status = csws_pkg::STS_FULL;
               shuffle(seed);
            end
            csws_pkg::ACT_PUSH: if (!put_top({rank, suit})) r.status = csws_pkg::STS_FULL;
            csws_pkg::ACT_APPEND: begin
               if (held >= DEPTH) r.status = csws_pkg::STS_FULL;
               else begin
                  cards[top + held[7:0]] = {rank, suit};
                  held++;
               end
            end
            csws_pkg::ACT_POP: begin
               if (held == 0) r.status = csws_pkg::STS_EMPTY;
               else begin
                  {r.rank, r.suit} = cards[top];
                  r.present = 1;
                  top = top + 8'd1;
                  held--;
               end
            end
            csws_pkg::ACT_SHUFFLE: shuffle(seed);
            default: ;
         endcase
         r.count = held[8:0];
         pending.push_back(r);
      endfunction

      function void check_reply(card_reply_type got);
         card_reply_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.rank !== want.rank) begin
            $display("%0t: out_rank expected %0d actual %0d", $time, want.rank, got.rank);
            errors++;
         end
         if (got.suit !== want.suit) begin
            $display("%0t: out_suit expected %0d actual %0d", $time, want.suit, got.suit);
            errors++;
         end
         if (got.present !== want.present) begin
            $display("%0t: card_present expected %0d actual %0d", $time, want.present,
                     got.present);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: card_count expected %0d actual %0d", $time, want.count, got.count);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [3:0]  req_card_rank = '0;
   logic [1:0]  req_card_suit = '0;
   logic [31:0] req_shuffle_seed = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [3:0]  rsp_out_rank;
   logic [1:0]  rsp_out_suit;
   logic        rsp_card_present;
   logic [1:0]  rsp_status;
   logic [8:0]  rsp_card_count;

   stack_scoreboard_type board = new();
   int unsigned phase = 0;
   int unsigned sent = 0;
   int unsigned idle_cycles = 0;
   bit hold_on = 0;

   card_stack_with_shuffle_core #(.STORE_DEPTH(DEPTH)) DUT (.*);

   always #10 clock = ~clock;

   task automatic send_action(logic [2:0] act, logic [3:0] rank, logic [1:0] suit,
                              logic [31:0] seed);
      int unsigned gap;
      req_valid <= 1;
      req_action <= act;
      req_card_rank <= rank;
      req_card_suit <= suit;
      req_shuffle_seed <= seed;
      do @(posedge clock); while (req_stall);
      board.note_request(act, rank, suit, seed);
      sent++;
      gap = (phase == 0) ? 9 : (phase == 1) ? 45 : 0;
      if ($urandom_range(99) < gap) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < gap);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      int unsigned pick, done;
      logic [2:0] act;
      logic [3:0] rank;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         phase = (done < RANDOM_ITEMS / 3) ? 0 : (done < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
         pick = $urandom_range(99);
         // keep the stack small so shuffles stay short
         if (board.held > 90 && pick < 55) pick = 70;
         if (pick < 2 && board.held < 120) act = csws_pkg::ACT_ADD_DECK;
         else if (pick < 6) act = csws_pkg::ACT_NEW_DECK;
         else if (pick < 11) act = csws_pkg::ACT_SHUFFLE;
         else if (pick < 40) act = csws_pkg::ACT_PUSH;
         else if (pick < 55) act = csws_pkg::ACT_APPEND;
         else if (pick < 96) act = csws_pkg::ACT_POP;
         else act = ($urandom_range(1) == 0) ? csws_pkg::ACT_SPARE_A : csws_pkg::ACT_SPARE_B;
         rank = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(13, 1));
         send_action(act, rank, 2'($urandom_range(3)), $urandom());
         done++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      // empty pop, append on empty, out-of-range ranks
      send_action(csws_pkg::ACT_POP, 4'd5, 2'd1, 32'd0);
      send_action(csws_pkg::ACT_APPEND, 4'd15, 2'd3, 32'd0);
      send_action(csws_pkg::ACT_PUSH, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_PUSH, 4'd14, 2'd2, 32'd0);
      send_action(csws_pkg::ACT_POP, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_SPARE_A, 4'd15, 2'd3, 32'hFFFF_FFFF);
      send_action(csws_pkg::ACT_POP, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_SPARE_B, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_SHUFFLE, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_POP, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_SHUFFLE, 4'd0, 2'd0, 32'd7);
      send_action(csws_pkg::ACT_NEW_DECK, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_SHUFFLE, 4'd0, 2'd0, 32'hFFFF_FFFF);
      // fill to the top with deck loads; the last one overflows
      send_action(csws_pkg::ACT_ADD_DECK, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_ADD_DECK, 4'd0, 2'd0, 32'h8000_0000);
      send_action(csws_pkg::ACT_ADD_DECK, 4'd0, 2'd0, 32'h1234_5678);
      send_action(csws_pkg::ACT_ADD_DECK, 4'd0, 2'd0, 32'hDEAD_BEEF);
      send_action(csws_pkg::ACT_PUSH, 4'd13, 2'd3, 32'd0);
      send_action(csws_pkg::ACT_APPEND, 4'd1, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_POP, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_APPEND, 4'd1, 2'd1, 32'd0);
      send_action(csws_pkg::ACT_NEW_DECK, 4'd0, 2'd0, 32'd0);
      send_action(csws_pkg::ACT_POP, 4'd0, 2'd0, 32'd0);
      // hold off until every response is in
      drain();
      send_random();
      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      int unsigned busy;
      if (rsp_valid && !rsp_stall)
         board.check_reply({rsp_out_rank, rsp_out_suit, rsp_card_present, rsp_status,
                            rsp_card_count});
      busy = (phase == 0) ? 45 : (phase == 1) ? 9 : 0;
      rsp_stall <= (!reset && (hold_on || $urandom_range(99) < busy));
   end

   // long receiver hold-off while the sender keeps offering beats
   initial begin
      wait (sent >= 100);
      @(posedge clock);
      hold_on <= 1;
      repeat (300) @(posedge clock);
      hold_on <= 0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule

@@ card_stack_with_shuffle_core.f @@
+incdir+hw/rtl
hw/rtl/csws_pkg.sv
hw/rtl/csws_store.sv
hw/rtl/csws_mod.sv
hw/rtl/card_stack_with_shuffle_core.sv
bench/testbench.sv
